// ===== rtl/trailing_silence_detector_top_macros.svh =====
// Assertion macros shared by the trailing silence detector.
// Define ASSERT_OFF to compile the checks away.
`ifndef TRAILING_SILENCE_DETECTOR_TOP_MACROS_SVH
`define TRAILING_SILENCE_DETECTOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tsd_pkg.sv =====
`default_nettype none

package tsd_pkg;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_COUNT_WIDTH  = 40;

    localparam int THRESHOLD_WIDTH = 15;
    localparam int REG_WIDTH       = 40;
    localparam int REPORT_WIDTH    = 40;
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [THRESHOLD_WIDTH-1:0] RST_NOISE_THRESHOLD = 15'd104;
    localparam logic [REG_WIDTH-1:0]       RST_MIN_SILENCE     = 40'd96000;
    localparam logic [REG_WIDTH-1:0]       RST_MIN_STREAM      = 40'd480000;
    localparam logic [REG_WIDTH-1:0]       RST_MARGIN          = 40'd12000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_NOISE_THRESHOLD = 3'd0,
        CFG_MIN_SILENCE     = 3'd1,
        CFG_MIN_STREAM      = 3'd2,
        CFG_MARGIN          = 3'd3
    } t_cfg_index;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_END    = 1'b1
    } t_command;

    typedef struct packed {
        logic [THRESHOLD_WIDTH-1:0] noise_threshold;
        logic [REG_WIDTH-1:0]       min_silence;
        logic [REG_WIDTH-1:0]       min_stream;
        logic [REG_WIDTH-1:0]       margin;
    } t_cfg;

    typedef struct packed {
        logic                    detected;
        logic [REPORT_WIDTH-1:0] quiet_begin;
        logic [REPORT_WIDTH-1:0] silence_length;
        logic [REPORT_WIDTH-1:0] stream_length;
        logic [REPORT_WIDTH-1:0] cut_point;
    } t_report;

endpackage

`default_nettype wire

// ===== rtl/trailing_silence_detector_top.sv =====
`default_nettype none
// Trailing silence detector.
//
// Input channel (i_valid / o_stall): one word per channel sample, channels of a
// sample position in a row with i_last_channel set on the last one. A word with
// i_command at end of stream ends the stream; its sample fields are ignored.
// Output channel (o_valid / i_stall): one report word per end-of-stream word,
// none for sample words. A word moves on a rising edge where valid is high and
// stall is low.
// Throughput is one input word per cycle while o_stall is low. Sample words
// are registered with their loudness compared against the threshold, then
// folded into the run state in the next cycle. An end-of-stream word goes from
// the input register to the result register, which drives o_valid. Input stall
// rises only when an end-of-stream word sits in the input register while an
// earlier report is held by a stalled receiver; sample words keep flowing past
// a waiting report. Configuration writes take effect on the next edge; the
// user must make them while the block is idle, which it does not enforce. Reset
// sets register defaults, clears run state, counter and both pipeline registers.
`include "trailing_silence_detector_top_macros.svh"

module trailing_silence_detector_top #(
    parameter int SAMPLE_WIDTH = tsd_pkg::DEF_SAMPLE_WIDTH,
    parameter int COUNT_WIDTH  = tsd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tsd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [tsd_pkg::REG_WIDTH-1:0]       i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_command,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  wire logic                                i_last_channel,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_detected,
    output logic [tsd_pkg::REPORT_WIDTH-1:0]         o_quiet_begin,
    output logic [tsd_pkg::REPORT_WIDTH-1:0]         o_silence_length,
    output logic [tsd_pkg::REPORT_WIDTH-1:0]         o_stream_length,
    output logic [tsd_pkg::REPORT_WIDTH-1:0]         o_cut_point
);
    import tsd_pkg::*;

    localparam int MAGW = (SAMPLE_WIDTH > THRESHOLD_WIDTH) ? SAMPLE_WIDTH : THRESHOLD_WIDTH;

    t_cfg    cfg;
    t_report core_report;

    logic                    r_s1_valid;
    logic                    r_s1_cmd;
    logic                    r_s1_loud;
    logic                    r_s1_last;
    logic                    r_out_valid;
    t_report                 r_out;

    logic [SAMPLE_WIDTH-1:0] sample_u;
    logic [SAMPLE_WIDTH-1:0] magnitude;
    logic                    loud;
    logic                    s1_adv;
    logic                    core_step;
    logic                    out_accept;

    tsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Magnitude as an unsigned value of the sample width, so the most negative
    // sample comes out as a power of two, above every threshold when SAMPLE_WIDTH > THRESHOLD_WIDTH.
    assign sample_u  = i_sample;
    assign magnitude = sample_u[SAMPLE_WIDTH-1] ? (~sample_u + 1'b1) : sample_u;
    assign loud      = MAGW'(magnitude) > MAGW'(cfg.noise_threshold);

    // Sample words never wait; an end-of-stream word waits only for room in
    // the result register.
    assign out_accept = r_out_valid && !i_stall;
    assign s1_adv     = !r_s1_valid || (t_command'(r_s1_cmd) == CMD_SAMPLE) ||
                        !r_out_valid || !i_stall;
    assign o_stall    = !s1_adv;
    assign core_step  = r_s1_valid && s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_s1_cmd  <= i_command;
            r_s1_loud <= loud;
            r_s1_last <= i_last_channel;
        end
    end

    tsd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (core_step),
        .i_command      (r_s1_cmd),
        .i_loud         (r_s1_loud),
        .i_last_channel (r_s1_last),
        .i_cfg          (cfg),
        .o_report       (core_report)
    );

    // Result register: loaded by an end-of-stream word, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_step && (t_command'(r_s1_cmd) == CMD_END)) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_step && (t_command'(r_s1_cmd) == CMD_END)) begin
            r_out <= core_report;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_detected       = r_out.detected;
    assign o_quiet_begin    = r_out.quiet_begin;
    assign o_silence_length = r_out.silence_length;
    assign o_stream_length  = r_out.stream_length;
    assign o_cut_point      = r_out.cut_point;

    // Back-pressure only arises with both registers occupied.
    `TSD_ASSERT_IMP(a_stall_needs_full, i_clk, i_rst_n, o_stall, r_s1_valid && r_out_valid)
    // An end-of-stream word always lands in the result register.
    `TSD_ASSERT_NXT(a_end_loads_result, i_clk, i_rst_n,
        core_step && (t_command'(r_s1_cmd) == CMD_END), r_out_valid)
    // The report returns the counter to zero for the next stream.
    `TSD_ASSERT_NXT(a_end_clears_count, i_clk, i_rst_n,
        core_step && (t_command'(r_s1_cmd) == CMD_END), core_report.stream_length == '0)

endmodule

`default_nettype wire

// ===== rtl/tsd_cfg.sv =====
`default_nettype none

module tsd_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tsd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [tsd_pkg::REG_WIDTH-1:0]       i_cfg_data,
    output tsd_pkg::t_cfg                            o_cfg
);
    import tsd_pkg::*;

    t_cfg r_cfg;

    // Writes to an index beyond the register list fall through the default arm.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_threshold <= RST_NOISE_THRESHOLD;
            r_cfg.min_silence     <= RST_MIN_SILENCE;
            r_cfg.min_stream      <= RST_MIN_STREAM;
            r_cfg.margin          <= RST_MARGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NOISE_THRESHOLD: begin
                    r_cfg.noise_threshold <= i_cfg_data[THRESHOLD_WIDTH-1:0];
                end
                CFG_MIN_SILENCE: begin
                    r_cfg.min_silence <= i_cfg_data;
                end
                CFG_MIN_STREAM: begin
                    r_cfg.min_stream <= i_cfg_data;
                end
                CFG_MARGIN: begin
                    r_cfg.margin <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/tsd_core.sv =====
`default_nettype none

module tsd_core #(
    parameter int COUNT_WIDTH = tsd_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire logic     i_command,
    input  wire logic     i_loud,
    input  wire logic     i_last_channel,
    input  tsd_pkg::t_cfg i_cfg,
    output tsd_pkg::t_report o_report
);
    import tsd_pkg::*;

    // Compare width covers both the counter and the 40-bit registers.
    localparam int CMPW = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    logic                   r_loud;
    logic                   r_run_open;
    logic [COUNT_WIDTH-1:0] r_run_start;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   loud_now;
    logic [COUNT_WIDTH-1:0] run_len;
    logic [CMPW-1:0]        count_x;
    logic [CMPW-1:0]        start_x;
    logic [CMPW-1:0]        len_x;
    logic [CMPW:0]          end_sum;
    logic [CMPW-1:0]        cut_x;
    logic                   detected;

    assign loud_now = r_loud | i_loud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loud      <= 1'b0;
            r_run_open  <= 1'b0;
            r_run_start <= '0;
            r_count     <= '0;
        end else if (i_step) begin
            if (t_command'(i_command) == CMD_END) begin
                r_loud      <= 1'b0;
                r_run_open  <= 1'b0;
                r_run_start <= '0;
                r_count     <= '0;
            end else if (i_last_channel) begin
                if (loud_now) begin
                    r_run_open <= 1'b0;
                end else if (!r_run_open) begin
                    r_run_open  <= 1'b1;
                    r_run_start <= r_count;
                end
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
                r_loud <= 1'b0;
            end else begin
                r_loud <= loud_now;
            end
        end
    end

    // The report is formed from the state as it stands before the end word.
    always_comb begin
        run_len  = r_run_open ? (r_count - r_run_start) : '0;
        count_x  = CMPW'(r_count);
        start_x  = CMPW'(r_run_start);
        len_x    = CMPW'(run_len);
        detected = r_run_open && (r_run_start != '0) &&
                   (count_x >= CMPW'(i_cfg.min_stream)) &&
                   (len_x >= CMPW'(i_cfg.min_silence));
        // A carry out of the sum means it lies beyond any count.
        end_sum  = {1'b0, start_x} + {1'b0, CMPW'(i_cfg.margin)};
        cut_x    = (end_sum < {1'b0, count_x}) ? end_sum[CMPW-1:0] : count_x;

        o_report.detected       = detected;
        o_report.quiet_begin    = detected ? start_x[REPORT_WIDTH-1:0] : '0;
        o_report.silence_length = len_x[REPORT_WIDTH-1:0];
        o_report.stream_length  = count_x[REPORT_WIDTH-1:0];
        o_report.cut_point      = detected ? cut_x[REPORT_WIDTH-1:0]
                                           : count_x[REPORT_WIDTH-1:0];
    end

endmodule

`default_nettype wire
